### rtl/rmsa_pkg.sv
// Package for the running mean / standard deviation / angle unit.
// Widths, constants, register indexes and controller/datapath interface types.
// No dependencies.
`default_nettype none
package rmsa_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int COUNT_BITS  = 16;
  localparam int FRAC_BITS   = 8;
  localparam int SUM_BITS    = 40;
  localparam int SQ_BITS     = 64;
  localparam int SD_BITS     = 23;
  localparam int V_BITS      = SAMPLE_BITS + 2;
  localparam int A_BITS      = 44;
  localparam int ND_BITS     = COUNT_BITS + 18;
  localparam int STEP_BITS   = 6;
  localparam int CIDX_BITS   = 2;

  localparam logic [ND_BITS-1:0] DEG360 = ND_BITS'(360 << FRAC_BITS);
  localparam logic signed [V_BITS-1:0] VMAX = V_BITS'(2**(SAMPLE_BITS-1) - 1);
  localparam logic signed [V_BITS-1:0] VMIN = -V_BITS'(2**(SAMPLE_BITS-1));
  localparam logic [SD_BITS-1:0] SD_MAX = '1;

  localparam logic [STEP_BITS-1:0] DIV_LAST  = STEP_BITS'(SQ_BITS - 1);
  localparam logic [STEP_BITS-1:0] SQRT_LAST = STEP_BITS'(SQ_BITS/2 - 1);

  localparam logic [CIDX_BITS-1:0] REG_ANGLE_MODE  = 2'd0;
  localparam logic [CIDX_BITS-1:0] REG_VOID_ENABLE = 2'd1;
  localparam logic [CIDX_BITS-1:0] REG_VOID_VALUE  = 2'd2;

  typedef struct packed {
    logic load;
    logic check;
    logic mul;
    logic up;
    logic dn;
    logic acc;
    logic div_init;
    logic div_sel_sq;
    logic div_step;
    logic mean;
    logic var_init;
    logic sqrt_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_void;
    logic is_full;
    logic angle_go;
    logic cnt_zero;
  } status_t;

  function automatic logic [A_BITS-1:0] abs_a(input logic signed [A_BITS-1:0] x);
    abs_a = x[A_BITS-1] ? A_BITS'(-x) : A_BITS'(x);
  endfunction

endpackage
`default_nettype wire

### rtl/rmsa_ctrl.sv
// Controller state machine: sequences sample check, angle shift, accumulation,
// two iterative divisions and the square root. Uses rmsa_pkg.
`default_nettype none
module rmsa_ctrl
  import rmsa_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_UP    = 4'd3;
  localparam logic [3:0] S_DN    = 4'd4;
  localparam logic [3:0] S_ACC   = 4'd5;
  localparam logic [3:0] S_DSET  = 4'd6;
  localparam logic [3:0] S_DRUN  = 4'd7;
  localparam logic [3:0] S_MEAN  = 4'd8;
  localparam logic [3:0] S_QSET  = 4'd9;
  localparam logic [3:0] S_QRUN  = 4'd10;
  localparam logic [3:0] S_VAR   = 4'd11;
  localparam logic [3:0] S_SQRT  = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  logic [3:0]           state_r, state_nxt;
  logic [STEP_BITS-1:0] step_r, step_nxt;
  logic                 out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (status.is_void || status.is_full) begin
          state_nxt = status.cnt_zero ? S_OUT : S_DSET;
        end else if (status.angle_go) begin
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_ACC;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_UP;
      end
      S_UP: begin
        cmd.up    = 1'b1;
        state_nxt = S_DN;
      end
      S_DN: begin
        cmd.dn    = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = S_DSET;
      end
      S_DSET: begin
        cmd.div_init = 1'b1;
        step_nxt     = '0;
        state_nxt    = S_DRUN;
      end
      S_DRUN: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == DIV_LAST) begin
          state_nxt = S_MEAN;
        end
      end
      S_MEAN: begin
        cmd.mean  = 1'b1;
        state_nxt = S_QSET;
      end
      S_QSET: begin
        cmd.div_init   = 1'b1;
        cmd.div_sel_sq = 1'b1;
        step_nxt       = '0;
        state_nxt      = S_QRUN;
      end
      S_QRUN: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == DIV_LAST) begin
          state_nxt = S_VAR;
        end
      end
      S_VAR: begin
        cmd.var_init = 1'b1;
        step_nxt     = '0;
        state_nxt    = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        step_nxt      = step_r + 1'b1;
        if (step_r == SQRT_LAST) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/rmsa_dp.sv
// Datapath: config registers, accumulators, angle shift, shared restoring
// divider, digit-by-digit square root and result registers. Uses rmsa_pkg.
`default_nettype none
module rmsa_dp
  import rmsa_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CIDX_BITS-1:0]   cfg_index,
  input  wire logic [SAMPLE_BITS-1:0] cfg_wdata,
  input  wire logic [SAMPLE_BITS-1:0] in_sample,
  input  wire cmd_t                   cmd,
  output status_t                     status,
  output logic [SAMPLE_BITS-1:0]      out_mean_out,
  output logic [SD_BITS-1:0]          out_std_dev,
  output logic [COUNT_BITS-1:0]       out_entry_count,
  output logic                        out_was_void,
  output logic                        out_was_dropped
);

  logic                          angle_r, void_en_r;
  logic [SAMPLE_BITS-1:0]        void_val_r;
  logic signed [SUM_BITS-1:0]    sum_r;
  logic [SQ_BITS-1:0]            sq_r;
  logic [COUNT_BITS-1:0]         count_r;
  logic signed [V_BITS-1:0]      v_r;
  logic signed [A_BITS-1:0]      a_r;
  logic [ND_BITS-1:0]            nd_r;
  logic                          void_flag_r, drop_flag_r;
  logic [SQ_BITS-1:0]            dvd_r;
  logic [COUNT_BITS:0]           rem_r;
  logic                          neg_r;
  logic signed [SAMPLE_BITS-1:0] m_r;
  logic [2*SAMPLE_BITS-1:0]      m2_r;
  logic [SQ_BITS-1:0]            rad_r;
  logic [SQ_BITS/2-1:0]          root_r;
  logic [SQ_BITS/2+1:0]          srem_r;

  logic signed [V_BITS+COUNT_BITS:0] nv;
  logic signed [A_BITS-1:0]      nd_s, t_up, t_dn;
  logic signed [V_BITS-1:0]      v_sat;
  logic signed [SAMPLE_BITS-1:0] vs;
  logic signed [2*SAMPLE_BITS-1:0] vsq;
  logic [SUM_BITS-1:0]           abs_sum;
  logic [COUNT_BITS:0]           rem_sh, rem_sub;
  logic                          q_bit;
  logic [SAMPLE_BITS:0]          qq;
  logic signed [2*SAMPLE_BITS-1:0] msq;
  logic [SQ_BITS/2+2:0]          srem_sh, trial;
  logic signed [SAMPLE_BITS+1:0] mo;
  logic [SD_BITS-1:0]            sd_val;

  assign status.is_void  = void_en_r && (v_r[SAMPLE_BITS-1:0] == void_val_r);
  assign status.is_full  = (count_r == '1);
  assign status.angle_go = angle_r && (count_r != '0);
  assign status.cnt_zero = (count_r == '0);

  assign nv   = v_r * $signed({1'b0, count_r});
  assign nd_s = $signed(A_BITS'(nd_r));
  assign t_up = a_r + nd_s;
  assign t_dn = a_r - nd_s;

  always_comb begin
    v_sat = v_r;
    if (v_r > VMAX) begin
      v_sat = VMAX;
    end else if (v_r < VMIN) begin
      v_sat = VMIN;
    end
  end
  assign vs      = v_sat[SAMPLE_BITS-1:0];
  assign vsq     = vs * vs;
  assign abs_sum = sum_r[SUM_BITS-1] ? SUM_BITS'(-sum_r) : SUM_BITS'(sum_r);

  assign rem_sh  = {rem_r[COUNT_BITS-1:0], dvd_r[SQ_BITS-1]};
  assign q_bit   = (rem_sh >= {1'b0, count_r});
  assign rem_sub = rem_sh - {1'b0, count_r};
  assign qq      = {1'b0, dvd_r[SAMPLE_BITS-1:0]}
                 + (SAMPLE_BITS+1)'(neg_r && (rem_r != '0));
  assign msq     = m_r * m_r;

  assign srem_sh = {srem_r[SQ_BITS/2:0], rad_r[SQ_BITS-1 -: 2]};
  assign trial   = {1'b0, root_r, 2'b01};

  always_comb begin
    mo = (SAMPLE_BITS+2)'(m_r);
    if (angle_r) begin
      if (mo < 0) begin
        mo = mo + $signed((SAMPLE_BITS+2)'(DEG360));
      end
      if (mo > $signed((SAMPLE_BITS+2)'(DEG360))) begin
        mo = mo - $signed((SAMPLE_BITS+2)'(DEG360));
      end
    end
    sd_val = (root_r > (SQ_BITS/2)'(SD_MAX)) ? SD_MAX : root_r[SD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r    <= 1'b0;
      void_en_r  <= 1'b0;
      void_val_r <= '0;
      sum_r      <= '0;
      sq_r       <= '0;
      count_r    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ANGLE_MODE:  angle_r    <= cfg_wdata[0];
          REG_VOID_ENABLE: void_en_r  <= cfg_wdata[0];
          REG_VOID_VALUE:  void_val_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.acc) begin
        sum_r   <= sum_r + SUM_BITS'(vs);
        sq_r    <= sq_r + SQ_BITS'(unsigned'(vsq));
        count_r <= count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v_r <= V_BITS'($signed(in_sample));
    end
    if (cmd.check) begin
      void_flag_r <= status.is_void;
      drop_flag_r <= !status.is_void && status.is_full;
    end
    if (cmd.mul) begin
      a_r  <= A_BITS'(nv) - A_BITS'(sum_r);
      nd_r <= ND_BITS'(count_r * DEG360);
    end
    if (cmd.up && (abs_a(t_up) < abs_a(a_r))) begin
      v_r <= v_r + $signed(V_BITS'(DEG360));
      a_r <= t_up;
    end
    if (cmd.dn && (abs_a(t_dn) < abs_a(a_r))) begin
      v_r <= v_r - $signed(V_BITS'(DEG360));
    end
    if (cmd.div_init) begin
      dvd_r <= cmd.div_sel_sq ? sq_r : SQ_BITS'(abs_sum);
      rem_r <= '0;
      if (!cmd.div_sel_sq) begin
        neg_r <= sum_r[SUM_BITS-1];
      end else begin
        m2_r <= unsigned'(msq);
      end
    end
    if (cmd.div_step) begin
      dvd_r <= {dvd_r[SQ_BITS-2:0], q_bit};
      rem_r <= q_bit ? rem_sub : rem_sh;
    end
    if (cmd.mean) begin
      m_r <= neg_r ? SAMPLE_BITS'(-qq) : SAMPLE_BITS'(qq);
    end
    if (cmd.var_init) begin
      rad_r  <= (dvd_r > SQ_BITS'(m2_r)) ? dvd_r - SQ_BITS'(m2_r) : '0;
      root_r <= '0;
      srem_r <= '0;
    end
    if (cmd.sqrt_step) begin
      rad_r <= {rad_r[SQ_BITS-3:0], 2'b00};
      if (srem_sh >= trial) begin
        srem_r <= (SQ_BITS/2+2)'(srem_sh - trial);
        root_r <= {root_r[SQ_BITS/2-2:0], 1'b1};
      end else begin
        srem_r <= srem_sh[SQ_BITS/2+1:0];
        root_r <= {root_r[SQ_BITS/2-2:0], 1'b0};
      end
    end
    if (cmd.out_load) begin
      out_entry_count <= count_r;
      out_was_void    <= void_flag_r;
      out_was_dropped <= drop_flag_r;
      if (count_r == '0) begin
        out_mean_out <= void_en_r ? void_val_r : '0;
        out_std_dev  <= '0;
      end else begin
        out_mean_out <= mo[SAMPLE_BITS-1:0];
        out_std_dev  <= sd_val;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/running_mean_stddev_angle_unit.sv
// Top level of the running mean / standard deviation / angle unit.
// Joins rmsa_ctrl and rmsa_dp; depends on rmsa_pkg.
//
// channel  direction  handshake            payload
// in       input      in_valid/in_ready    in_sample
// out      output     out_valid/out_ready  mean_out, std_dev, entry_count, flags
// cfg      input      cfg_we               cfg_index, cfg_wdata
//
// A sample passes the angle shift before accumulation in angle mode with entries
// present; a void or dropped sample skips accumulation, and a void sample with
// no entries goes straight to the result. Two 64-step restoring divisions and
// a 32-step square root follow; one sample is in work at a time. A finished
// result waits in the output register while the next sample is accepted. Reset
// is synchronous, active low, and clears the accumulators and configuration.
`default_nettype none
module running_mean_stddev_angle_unit
  import rmsa_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CIDX_BITS-1:0]   cfg_index,
  input  wire logic [SAMPLE_BITS-1:0] cfg_wdata,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [SAMPLE_BITS-1:0] in_sample,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [SAMPLE_BITS-1:0]      out_mean_out,
  output logic [SD_BITS-1:0]          out_std_dev,
  output logic [COUNT_BITS-1:0]       out_entry_count,
  output logic                        out_was_void,
  output logic                        out_was_dropped
);

  cmd_t    cmd;
  status_t status;

  rmsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  rmsa_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_sample       (in_sample),
    .cmd             (cmd),
    .status          (status),
    .out_mean_out    (out_mean_out),
    .out_std_dev     (out_std_dev),
    .out_entry_count (out_entry_count),
    .out_was_void    (out_was_void),
    .out_was_dropped (out_was_dropped)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second sample accepted while busy");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_was_void && out_was_dropped))
    else $error("void and dropped both set");

  a_empty_no_dev: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_entry_count == '0) |-> (out_std_dev == '0))
    else $error("deviation reported with no entries");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_was_dropped |-> (out_entry_count == '1))
    else $error("drop reported below full count");

endmodule
`default_nettype wire
